// File: src/dpc_pkg.sv
// ----------------------------------------------------------------------------
// Dark pixel centroid package
// Shared widths, register indexes, reset values, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

    // Payload widths
    localparam int PIX_W    = 8;
    localparam int THR_W    = 8;
    localparam int CFG_W    = 13;
    localparam int CENTER_W = 13;
    localparam int COUNT_W  = 25;

    // Frame size limits (defaults of the top-level parameters)
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    // Configuration reset values
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd225;
    localparam logic [CFG_W-1:0] WIDTH_RESET     = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET    = 13'd480;

    typedef enum logic [2:0] {
        ST_PIXEL,
        ST_START_X,
        ST_DIV_X,
        ST_DIV_Y,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic pix_accept;
        logic div_start;
        logic div_sel_y;
        logic latch_x;
        logic latch_y;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/dpc_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpc_pixel_if import dpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: src/dpc_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one frame centroid per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpc_result_if import dpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [COUNT_W-1:0]  dark_count;

    modport source (output valid, output center_x, output center_y, output dark_count,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input dark_count,
                    output ready);
endinterface

`default_nettype wire

// File: src/dpc_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_div #(
    parameter int DVD_W = 37,
    parameter int DVS_W = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // Remainder stays below the divisor, so it fits in DVS_W bits
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/dpc_ctrl.sv
// ----------------------------------------------------------------------------
// Centroid controller
// Sequences pixel intake, the two divisions and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_ctrl import dpc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PIXEL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_PIXEL: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.pix_accept = 1'b1;
                    if (i_sts.frame_end) begin
                        n_state = ST_START_X;
                    end
                end
            end
            ST_START_X: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_x   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state         = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_y = 1'b1;
                    n_state       = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_PIXEL;
                end
            end
            default: begin
                n_state = ST_PIXEL;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/dpc_datapath.sv
// ----------------------------------------------------------------------------
// Centroid datapath
// Config registers, raster position, accumulators, divider and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_datapath import dpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [PIX_W-1:0]     i_red,
    input  wire logic [PIX_W-1:0]     i_green,
    input  wire logic [PIX_W-1:0]     i_blue,
    input  wire logic                 i_out_ready,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output logic                      o_out_valid,
    output logic      [CENTER_W-1:0]  o_center_x,
    output logic      [CENTER_W-1:0]  o_center_y,
    output logic      [COUNT_W-1:0]   o_dark_count
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_W  = CW + RW + 1;
    localparam int CSUM_W = CNT_W + CW;
    localparam int RSUM_W = CNT_W + RW;
    localparam int DIV_W  = (CSUM_W > RSUM_W) ? CSUM_W : RSUM_W;

    // Configuration
    logic [THR_W-1:0] r_thr;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THRESHOLD_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                REG_WIDTH:     r_width  <= i_cfg_data;
                REG_HEIGHT:    r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Last column/row index after clamping size to 1..MAX
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;

    always_comb begin
        if (r_width == '0) begin
            last_col = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(r_width - 1'b1);
        end
        if (r_height == '0) begin
            last_row = '0;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(r_height - 1'b1);
        end
    end

    // Position and accumulators
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CNT_W-1:0]  r_cnt;
    logic [CSUM_W-1:0] r_csum;
    logic [RSUM_W-1:0] r_rsum;

    logic [CNT_W-1:0]  n_cnt;
    logic [CSUM_W-1:0] n_csum;
    logic [RSUM_W-1:0] n_rsum;
    logic              dark;
    logic              row_end;
    logic              frame_end;

    always_comb begin
        dark      = (i_red <= r_thr) && (i_green <= r_thr) && (i_blue <= r_thr);
        row_end   = r_col >= last_col;
        frame_end = row_end && (r_row >= last_row);
        n_cnt     = r_cnt + CNT_W'(dark);
        n_csum    = dark ? r_csum + CSUM_W'(r_col) + 1'b1 : r_csum;
        n_rsum    = dark ? r_rsum + RSUM_W'(r_row) + 1'b1 : r_rsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
            r_csum <= '0;
            r_rsum <= '0;
        end else if (i_cmd.pix_accept) begin
            if (frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_cnt  <= '0;
                r_csum <= '0;
                r_rsum <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_csum <= n_csum;
                r_rsum <= n_rsum;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Frame snapshot, held while the divider works
    logic [CNT_W-1:0]  r_snap_cnt;
    logic [CSUM_W-1:0] r_snap_csum;
    logic [RSUM_W-1:0] r_snap_rsum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_accept && frame_end) begin
            r_snap_cnt  <= n_cnt;
            r_snap_csum <= n_csum;
            r_snap_rsum <= n_rsum;
        end
    end

    // Shared divider: column sum first, then row sum
    logic             div_done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] dividend;

    assign dividend = i_cmd.div_sel_y ? DIV_W'(r_snap_rsum) : DIV_W'(r_snap_csum);

    dpc_div #(
        .DVD_W (DIV_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_snap_cnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    logic [CENTER_W-1:0] r_cx;
    logic [CENTER_W-1:0] r_cy;
    logic [CENTER_W-1:0] center;

    // Empty frame reports 1 on each axis
    assign center = (r_snap_cnt == '0) ? CENTER_W'(1) : CENTER_W'(quotient);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_x) begin
            r_cx <= center;
        end
        if (i_cmd.latch_y) begin
            r_cy <= center;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_center_x   <= r_cx;
            o_center_y   <= r_cy;
            o_dark_count <= COUNT_W'(r_snap_cnt);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.frame_end = frame_end;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// File: src/dark_pixel_centroid.sv
// ----------------------------------------------------------------------------
// Dark pixel centroid
// Per-frame centroid and count of pixels darker than a threshold.
// ----------------------------------------------------------------------------
// Usage:
//  - i_pixel takes one RGB pixel per transaction in raster order; the block
//    tracks column and row itself from frame_width / frame_height.
//  - A pixel is dark when R, G and B are all <= dark_threshold.
//  - o_result gives one transaction per frame after its last pixel:
//    truncated mean 1-based column and row of the dark pixels (1/1 when
//    none were dark) and the dark pixel count.
//  - Config: i_cfg_we writes i_cfg_data to register i_cfg_index
//    (0 threshold, 1 width, 2 height; index 3 ignored). Write only when idle.
//  - Throughput: one pixel per clock within a frame. After the last pixel
//    of a frame input is held off while a single shift-subtract divider
//    computes X then Y, one quotient bit per cycle. The result goes valid
//    and input reopens in the same cycle.
//  - The result sits in an output register; if the receiver stalls, the
//    block still finishes both divisions and then waits for the register
//    to drain before taking the next frame's pixels.
//  - Reset (synchronous, active low) restores default config and clears
//    position, accumulators and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_pixel_centroid import dpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    dpc_pixel_if.sink                 i_pixel,
    dpc_result_if.source              o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // Sequencer: pixel intake, X divide, Y divide, hand-off
    dpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pixel.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_pixel.ready = in_ready;

    // Accumulators, divider and the output register
    dpc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_pixel.red),
        .i_green      (i_pixel.green),
        .i_blue       (i_pixel.blue),
        .i_out_ready  (o_result.ready),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_result.valid),
        .o_center_x   (o_result.center_x),
        .o_center_y   (o_result.center_y),
        .o_dark_count (o_result.dark_count)
    );

endmodule

`default_nettype wire
